// ===== rtl/chorus_pkg.sv =====
`default_nettype none

package chorus_pkg;

    // sample and stream widths
    localparam int SAMPLE_BITS   = 16;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 32;

    // ring buffer default depth
    localparam int CHORUS_BUFFER_DEPTH = 2048;

    // lfo table
    localparam int LFO_DEPTH     = 1024;
    localparam int LFO_ADDR_BITS = 10;
    localparam int LFO_BITS      = 16;

    // configuration registers
    localparam int PHASE_BITS    = 32;
    localparam int DELAY_Q8_BITS = 19;
    localparam int DELAY_BITS    = DELAY_Q8_BITS + 1;
    localparam int TAP_FULL_BITS = DELAY_BITS - 8;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DELAY  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_SPAN = 2'd2;

    localparam logic [PHASE_BITS-1:0]    PHASE_STEP_RST = 32'd178957;
    localparam logic [DELAY_Q8_BITS-1:0] MIN_DELAY_RST  = 19'd122880;
    localparam logic [DELAY_Q8_BITS-1:0] DELAY_SPAN_RST = 19'd184320;

    // fixed point constants for the table build
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef logic [LFO_BITS-1:0] t_lfo_rom [LFO_DEPTH];

    // sine in q30 for an angle in [0, pi/2], taylor series to x^15
    function automatic longint sine_quarter(input longint x);
        longint x2;
        longint term;
        longint sum;
        x2   = (x * x) / ONE_Q30;
        term = x;
        sum  = x;
        term = -((term * x2) / ONE_Q30) / 6;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 20;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 42;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 72;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 110;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 156;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 210;
        sum  = sum + term;
        return sum;
    endfunction

    // sine in q30 for an angle in [0, 2*pi)
    function automatic longint sine_full(input longint theta_in);
        longint theta;
        bit     neg;
        theta = theta_in;
        neg   = 1'b0;
        if (theta > PI_Q30) begin
            theta = theta - PI_Q30;
            neg   = 1'b1;
        end
        if (theta > PI_Q30 / 2) begin
            theta = PI_Q30 - theta;
        end
        return neg ? -sine_quarter(theta) : sine_quarter(theta);
    endfunction

    // (sin(sin(2*pi*k/N)) + 1) / 2 in q0.16
    function automatic t_lfo_rom build_lfo_rom();
        t_lfo_rom rom;
        longint   theta;
        longint   s1;
        longint   s2;
        longint   v;
        for (int k = 0; k < LFO_DEPTH; k++) begin
            theta  = (2 * PI_Q30 * longint'(k)) / LFO_DEPTH;
            s1     = sine_full(theta);
            s2     = (s1 < 0) ? -sine_quarter(-s1) : sine_quarter(s1);
            v      = (s2 + ONE_Q30 + 64'sd16384) >>> 15;
            rom[k] = v[LFO_BITS-1:0];
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/chorus_modulated_delay.sv =====
// Chorus: lfo-modulated fractional delay line.
// Input stream s_axis carries one dry sample per transfer (tdata[15:0]).
// Output stream m_axis carries one result per input transfer:
//   tdata[15:0] mixed_out (dry plus wet, saturated), tdata[31:16] wet_out.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_addr
//   (0 phase step, 1 minimum delay q8, 2 delay span q8); other indexes ignored.
//   Write only while the block is idle.
// Each sample is written to a ring buffer memory; the lfo rom, a multiply,
// the tap address and two buffer reads follow, then interpolation and mixing.
// The mix step loads the result into the output register. A new sample is
// taken only in the idle state, after the previous one has passed the chain
// rom read, multiply, address, buffer read, interpolate.
// The output register decouples the sides: a new sample is taken while a
// result waits; a stalled receiver holds the next result in the mix step.
// Reset clears the write pointer, the lfo phase and the fill count and loads the
// register defaults; unwritten buffer entries read as zero through the fill
// count, so no clearing pass is needed.
`default_nettype none

module chorus_modulated_delay #(
    parameter int BUFFER_DEPTH = chorus_pkg::CHORUS_BUFFER_DEPTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // sample_in
    input  wire logic [chorus_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // mixed_out [15:0], wet_out [31:16]
    output logic [chorus_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    input  wire logic                                 i_cfg_we,
    input  wire logic [chorus_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [chorus_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import chorus_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CMP_W  = ((TAP_FULL_BITS > ADDR_W) ? TAP_FULL_BITS : ADDR_W) + 1;
    localparam int PROD_W = DELAY_Q8_BITS + LFO_BITS;
    localparam int ACC_W  = SAMPLE_BITS + 10;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_DEPTH - 1);
    localparam t_lfo_rom LFO_ROM = build_lfo_rom();

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_READ,
        S_MIX
    } t_state;

    t_state                         r_state;
    logic [PHASE_BITS-1:0]          r_phase_step;
    logic [DELAY_Q8_BITS-1:0]       r_min_delay;
    logic [DELAY_Q8_BITS-1:0]       r_delay_span;
    logic [PHASE_BITS-1:0]          r_phase;
    logic [ADDR_W-1:0]              r_wp;
    logic [ADDR_W:0]                r_fill;
    logic signed [SAMPLE_BITS-1:0]  r_x;
    logic [LFO_BITS-1:0]            r_lfo;
    logic [DELAY_Q8_BITS-1:0]       r_scaled;
    logic [ADDR_W-1:0]              r_p1;
    logic [7:0]                     r_f;
    logic                           r_v1;
    logic                           r_v2;
    logic signed [SAMPLE_BITS-1:0]  r_s1;
    logic signed [SAMPLE_BITS-1:0]  r_s2;
    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_mixed;
    logic signed [SAMPLE_BITS-1:0]  r_wet;

    logic signed [SAMPLE_BITS-1:0]  ring_mem [BUFFER_DEPTH];

    logic                           in_xfer;
    logic                           out_free;
    logic [PROD_W-1:0]              span_prod;
    logic [DELAY_BITS-1:0]          delay_q8;
    logic [TAP_FULL_BITS-1:0]       tap_full;
    logic                           tap_clamp;
    logic [ADDR_W-1:0]              tap_int;
    logic [ADDR_W:0]                tap_sum;
    logic [ADDR_W-1:0]              n_p1;
    logic [7:0]                     n_f;
    logic [ADDR_W-1:0]              p2;
    logic signed [SAMPLE_BITS-1:0]  s1_eff;
    logic signed [SAMPLE_BITS-1:0]  s2_eff;
    logic [8:0]                     w1;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        acc_rnd;
    logic signed [SAMPLE_BITS-1:0]  n_wet;
    logic signed [SAMPLE_BITS:0]    mix_sum;
    logic signed [SAMPLE_BITS-1:0]  n_mixed;

    // handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_wet, r_mixed};

    // lfo scaling of the delay span
    assign span_prod = PROD_W'(r_delay_span) * PROD_W'(r_lfo);

    // delay split into integer tap and fraction, clamped below the depth
    always_comb begin
        delay_q8  = DELAY_BITS'(r_min_delay) + DELAY_BITS'(r_scaled);
        tap_full  = delay_q8[DELAY_BITS-1:8];
        tap_clamp = CMP_W'(tap_full) >= CMP_W'(BUFFER_DEPTH - 1);
        tap_int   = tap_clamp ? LAST_ADDR : ADDR_W'(tap_full);
        n_f       = tap_clamp ? 8'd0 : delay_q8[7:0];
        tap_sum   = {1'b0, r_wp} + (ADDR_W + 1)'(BUFFER_DEPTH) - {1'b0, tap_int};
        if (tap_sum >= (ADDR_W + 1)'(BUFFER_DEPTH)) begin
            n_p1 = ADDR_W'(tap_sum - (ADDR_W + 1)'(BUFFER_DEPTH));
        end else begin
            n_p1 = ADDR_W'(tap_sum);
        end
    end

    // second tap, one sample older
    assign p2 = (r_p1 == '0) ? LAST_ADDR : (r_p1 - 1'b1);

    // interpolation and mix
    always_comb begin
        s1_eff  = r_v1 ? r_s1 : '0;
        if (r_f == 8'd0) begin
            s2_eff = s1_eff;
        end else begin
            s2_eff = r_v2 ? r_s2 : '0;
        end
        w1      = 9'd256 - {1'b0, r_f};
        acc     = ACC_W'(s1_eff) * $signed(ACC_W'(w1))
                + ACC_W'(s2_eff) * $signed(ACC_W'(r_f));
        acc_rnd = acc + ACC_W'(128);
        n_wet   = acc_rnd[SAMPLE_BITS+7:8];
        mix_sum = {r_x[SAMPLE_BITS-1], r_x} + {n_wet[SAMPLE_BITS-1], n_wet};
        if (mix_sum[SAMPLE_BITS] != mix_sum[SAMPLE_BITS-1]) begin
            n_mixed = mix_sum[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                           : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            n_mixed = mix_sum[SAMPLE_BITS-1:0];
        end
    end

    // ring buffer and lfo rom
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            ring_mem[r_wp] <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_lfo          <= LFO_ROM[r_phase[PHASE_BITS-1 -: LFO_ADDR_BITS]];
        end
        r_s1 <= ring_mem[r_p1];
        r_s2 <= ring_mem[p2];
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase_step <= PHASE_STEP_RST;
            r_min_delay  <= MIN_DELAY_RST;
            r_delay_span <= DELAY_SPAN_RST;
            r_phase      <= '0;
            r_wp         <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_PHASE_STEP: r_phase_step <= i_cfg_data[PHASE_BITS-1:0];
                    CFG_MIN_DELAY:  r_min_delay  <= i_cfg_data[DELAY_Q8_BITS-1:0];
                    CFG_DELAY_SPAN: r_delay_span <= i_cfg_data[DELAY_Q8_BITS-1:0];
                    default: ;
                endcase
            end
            // output transfer empties the register unless the mix step reloads it
            if (r_out_valid && m_axis_tready && (r_state != S_MIX)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_x <= s_axis_tdata[SAMPLE_BITS-1:0];
                        if (r_fill != (ADDR_W + 1)'(BUFFER_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_scaled <= span_prod[PROD_W-1:LFO_BITS];
                    r_state  <= S_ADDR;
                end
                S_ADDR: begin
                    r_p1    <= n_p1;
                    r_f     <= n_f;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_v1    <= {1'b0, r_p1} < r_fill;
                    r_v2    <= {1'b0, p2} < r_fill;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    if (out_free) begin
                        r_mixed     <= n_mixed;
                        r_wet       <= n_wet;
                        r_out_valid <= 1'b1;
                        r_wp        <= (r_wp == LAST_ADDR) ? '0 : (r_wp + 1'b1);
                        r_phase     <= r_phase + r_phase_step;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (ADDR_W + 1)'(BUFFER_DEPTH))
        else $error("fill count beyond buffer depth");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= LAST_ADDR)
        else $error("write pointer beyond buffer depth");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_MUL))
        else $error("accepted sample did not start processing");

    a_mix_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX && r_out_valid && !m_axis_tready)
            |=> (r_state == S_MIX) && $stable(r_wp) && $stable(r_phase))
        else $error("result overwritten while receiver stalls");

    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_p1 <= LAST_ADDR))
        else $error("tap address beyond buffer depth");
`endif

endmodule

`default_nettype wire

// ===== dv/chorus_modulated_delay_tb.sv =====
`timescale 1ns / 1ps

module chorus_modulated_delay_tb;

    localparam int     HIST_DEPTH   = chorus_pkg::CHORUS_BUFFER_DEPTH;
    localparam int     LFO_ENTRIES  = chorus_pkg::LFO_DEPTH;
    localparam longint Q30_ONE      = 64'sd1073741824;
    localparam longint Q30_PI       = 64'sd3373259426;
    localparam longint SAT_MAX      = 32767;
    localparam longint SAT_MIN      = -32768;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     HOLD_CYCLES  = 80;
    localparam int     RAND_PHASES  = 6;
    localparam int     RAND_ITEMS   = 90;
    localparam int     CYCLE_LIMIT  = 300000;

    // index that decodes to no register
    localparam logic [chorus_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] wet;
        logic [15:0] mixed;
    } t_mix_result;

    typedef enum logic [2:0] {
        ROW_SAMPLE, ROW_CHECKED, ROW_STEP, ROW_MIN, ROW_SPAN, ROW_BAD_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] value;
        logic [15:0] exp_mixed;
        logic [15:0] exp_wet;
    } t_stim_row;

    logic                                     i_clk;
    logic                                     i_rst_n;
    logic [chorus_pkg::IN_TDATA_W-1:0]        s_axis_tdata;
    logic                                     s_axis_tvalid;
    logic                                     s_axis_tready;
    logic [chorus_pkg::OUT_TDATA_W-1:0]       m_axis_tdata;
    logic                                     m_axis_tvalid;
    logic                                     m_axis_tready;
    logic                                     i_cfg_we;
    logic [chorus_pkg::CFG_ADDR_W-1:0]        i_cfg_addr;
    logic [chorus_pkg::CFG_DATA_W-1:0]        i_cfg_data;

    chorus_modulated_delay uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // chorus state mirrored on the bench side
    logic [15:0]                        lfo_rom [LFO_ENTRIES];
    logic signed [15:0]                 sample_hist [HIST_DEPTH];
    int                                 hist_wr;
    logic [31:0]                        lfo_acc;
    logic [31:0]                        step_reg;
    logic [chorus_pkg::DELAY_Q8_BITS-1:0] min_reg;
    logic [chorus_pkg::DELAY_Q8_BITS-1:0] span_reg;

    t_mix_result pending_mixes [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          tx_calm;
    bit          rx_calm;
    bit          hold_request = 1'b0;

    // directed rows: extremes after reset, zero delay with saturation,
    // half-sample interpolation, delay past the buffer, ignored register bits
    t_stim_row dir_rows [33] = '{
        '{ROW_CHECKED, 32'h0000_7FFF, 16'h7FFF, 16'h0000},
        '{ROW_CHECKED, 32'h0000_8000, 16'h8000, 16'h0000},
        '{ROW_CHECKED, 32'h0000_0000, 16'h0000, 16'h0000},
        '{ROW_CHECKED, 32'h0000_FFFF, 16'hFFFF, 16'h0000},
        '{ROW_CHECKED, 32'h0000_0001, 16'h0001, 16'h0000},
        '{ROW_CHECKED, 32'h0000_5555, 16'h5555, 16'h0000},
        '{ROW_CHECKED, 32'h0000_AAAA, 16'hAAAA, 16'h0000},
        '{ROW_MIN,     32'h0000_0000, 16'h0000, 16'h0000},
        '{ROW_SPAN,    32'h0000_0000, 16'h0000, 16'h0000},
        '{ROW_STEP,    32'h0000_0000, 16'h0000, 16'h0000},
        '{ROW_CHECKED, 32'h0000_7FFF, 16'h7FFF, 16'h7FFF},
        '{ROW_CHECKED, 32'h0000_8000, 16'h8000, 16'h8000},
        '{ROW_CHECKED, 32'h0000_0064, 16'h00C8, 16'h0064},
        '{ROW_CHECKED, 32'h0000_FFFF, 16'hFFFE, 16'hFFFF},
        '{ROW_MIN,     32'd384,       16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_03E8, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_F448, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_0007, 16'h0000, 16'h0000},
        '{ROW_MIN,     32'd523776,    16'h0000, 16'h0000},
        '{ROW_SPAN,    32'd523776,    16'h0000, 16'h0000},
        '{ROW_STEP,    32'hFFFF_FFFF, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_3039, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_CFC7, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_0000, 16'h0000, 16'h0000},
        '{ROW_BAD_REG, 32'hFFFF_FFFF, 16'h0000, 16'h0000},
        '{ROW_MIN,     32'hFFF8_03E8, 16'h0000, 16'h0000},
        '{ROW_SPAN,    32'h0002_D000, 16'h0000, 16'h0000},
        '{ROW_STEP,    32'h4000_0000, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_7FFF, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_8001, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_1234, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_EDCB, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,  32'h0000_0100, 16'h0000, 16'h0000}
    };

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("chorus_modulated_delay_tb: errors");
            $finish;
        end
    end

    // sine in q30 on [0, pi/2], taylor series up to x^15
    function automatic longint lfo_sin_q30(input longint a);
        longint a2;
        longint t;
        longint acc;
        a2  = (a * a) / Q30_ONE;
        t   = a;
        acc = a;
        for (int i = 1; i <= 7; i++) begin
            t   = -((t * a2) / Q30_ONE) / longint'((2 * i) * (2 * i + 1));
            acc = acc + t;
        end
        return acc;
    endfunction

    // sine in q30 over a full turn, folded onto the first quadrant
    function automatic longint lfo_sin_turn(input longint ang);
        longint a;
        bit     flip;
        a    = ang;
        flip = 1'b0;
        if (a > Q30_PI) begin
            a    = a - Q30_PI;
            flip = 1'b1;
        end
        if (a > Q30_PI / 2) begin
            a = Q30_PI - a;
        end
        return flip ? -lfo_sin_q30(a) : lfo_sin_q30(a);
    endfunction

    // one sample through the modulated delay: write, tap, interpolate, mix
    function automatic t_mix_result delay_and_mix(input logic [15:0] raw);
        t_mix_result res;
        longint      dry;
        longint      dly;
        longint      taps;
        longint      frac;
        longint      s1;
        longint      s2;
        longint      wet;
        longint      mix;
        int          rd1;
        int          rd2;
        dry = longint'(signed'(raw));
        sample_hist[hist_wr] = raw;
        dly = longint'(min_reg) + ((longint'(span_reg) *
              longint'(lfo_rom[lfo_acc[31 -: chorus_pkg::LFO_ADDR_BITS]])) >>> 16);
        taps = dly >>> 8;
        frac = dly & 255;
        // delay past the buffer pins to the oldest entry, no interpolation
        if (taps >= HIST_DEPTH - 1) begin
            taps = HIST_DEPTH - 1;
            frac = 0;
        end
        rd1 = int'((hist_wr + HIST_DEPTH - taps) % HIST_DEPTH);
        rd2 = int'((hist_wr + 2 * HIST_DEPTH - taps - 1) % HIST_DEPTH);
        s1  = longint'(sample_hist[rd1]);
        s2  = (frac != 0) ? longint'(sample_hist[rd2]) : s1;
        wet = (s1 * (256 - frac) + s2 * frac + 128) >>> 8;
        mix = dry + wet;
        if (mix > SAT_MAX) mix = SAT_MAX;
        if (mix < SAT_MIN) mix = SAT_MIN;
        hist_wr = (hist_wr + 1) % HIST_DEPTH;
        lfo_acc = lfo_acc + step_reg;
        res.mixed = 16'(mix);
        res.wet   = 16'(wet);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    // offer one sample, record what it should produce once it is taken
    task automatic send_sample(input logic [15:0] smp, input bit typed,
                               input t_mix_result typed_exp);
        t_mix_result predicted;
        int          gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predicted = delay_and_mix(smp);
        pending_mixes.push_back(typed ? typed_exp : predicted);
    endtask

    // register write, mirrored into the local copy at the same edge
    task automatic write_reg(input logic [chorus_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (addr)
            chorus_pkg::CFG_PHASE_STEP: step_reg = value;
            chorus_pkg::CFG_MIN_DELAY:  min_reg  = value[chorus_pkg::DELAY_Q8_BITS-1:0];
            chorus_pkg::CFG_DELAY_SPAN: span_reg = value[chorus_pkg::DELAY_Q8_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stop offering and let every outstanding result come out
    task automatic drain_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_mixes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int          gap;
        t_mix_result want;
        bit          hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                end
            end
            gap = rx_calm ? 0 : $urandom_range(0, 8);
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            if (pending_mixes.size() == 0) begin
                report_mismatch($sformatf("transfer %h with nothing pending", m_axis_tdata));
            end else begin
                want = pending_mixes.pop_front();
                if (m_axis_tdata[15:0] !== want.mixed) begin
                    report_mismatch($sformatf("mixed_out %h, want %h",
                                              m_axis_tdata[15:0], want.mixed));
                end
                if (m_axis_tdata[31:16] !== want.wet) begin
                    report_mismatch($sformatf("wet_out %h, want %h",
                                              m_axis_tdata[31:16], want.wet));
                end
            end
        end
    end

    // main sequence
    initial begin : stimulus
        t_stim_row   row;
        t_mix_result want;
        t_mix_result unused_exp;
        logic [31:0] step;
        logic [31:0] min_q8;
        logic [31:0] span_q8;
        logic [15:0] smp;
        longint      s;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = chorus_pkg::CFG_PHASE_STEP;
        i_cfg_data     = '0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        unused_exp     = '0;

        // lfo table: sin(sin(x)) shifted to unsigned q0.16
        for (int k = 0; k < LFO_ENTRIES; k++) begin
            s = lfo_sin_turn((2 * Q30_PI * longint'(k)) / LFO_ENTRIES);
            s = (s < 0) ? -lfo_sin_q30(-s) : lfo_sin_q30(s);
            lfo_rom[k] = 16'((s + Q30_ONE + 64'sd16384) >>> 15);
        end
        foreach (sample_hist[i]) sample_hist[i] = '0;
        hist_wr  = 0;
        lfo_acc  = '0;
        step_reg = chorus_pkg::PHASE_STEP_RST;
        min_reg  = chorus_pkg::MIN_DELAY_RST;
        span_reg = chorus_pkg::DELAY_SPAN_RST;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            case (row.kind)
                ROW_SAMPLE, ROW_CHECKED: begin
                    want.mixed = row.exp_mixed;
                    want.wet   = row.exp_wet;
                    send_sample(row.value[15:0], row.kind == ROW_CHECKED, want);
                end
                ROW_STEP: begin
                    drain_block();
                    write_reg(chorus_pkg::CFG_PHASE_STEP, row.value);
                end
                ROW_MIN: begin
                    drain_block();
                    write_reg(chorus_pkg::CFG_MIN_DELAY, row.value);
                end
                ROW_SPAN: begin
                    drain_block();
                    write_reg(chorus_pkg::CFG_DELAY_SPAN, row.value);
                end
                default: begin
                    drain_block();
                    write_reg(CFG_UNUSED, row.value);
                end
            endcase
        end

        // random phases, each with its own lfo rate and delay range
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_block();
            case ($urandom_range(0, 3))
                0:       step = $urandom;
                1:       step = $urandom_range(0, 32'h00FF_FFFF);
                2:       step = $urandom_range(32'h0400_0000, 32'h2000_0000);
                default: step = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
            endcase
            min_q8  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 523776)
                                                 : $urandom_range(0, 24 * 256);
            span_q8 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 523776)
                                                 : $urandom_range(0, 48 * 256);
            write_reg(chorus_pkg::CFG_PHASE_STEP, step);
            write_reg(chorus_pkg::CFG_MIN_DELAY, ($urandom & 32'hFFF8_0000) | min_q8);
            write_reg(chorus_pkg::CFG_DELAY_SPAN, ($urandom & 32'hFFF8_0000) | span_q8);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_UNUSED, $urandom);
            end
            // one back-to-back phase, one phase where the sink holds off
            tx_calm = (ph == 1) || (ph == 3);
            rx_calm = (ph == 1);
            if (ph == 3) hold_request = 1'b1;
            repeat (RAND_ITEMS) begin
                if ($urandom_range(0, 7) == 0) begin
                    smp = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
                end else begin
                    smp = 16'($urandom);
                end
                send_sample(smp, 1'b0, unused_exp);
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        drain_block();
        if (mismatch_count == 0) begin
            $display("chorus_modulated_delay_tb: clean");
        end else begin
            $display("chorus_modulated_delay_tb: errors");
        end
        $finish;
    end

endmodule
